// ----- sv/lpsp_pkg.sv -----
// Shared types, widths and constants of the lidar point spherical projector.
// Used by sv/lidar_point_spherical_projector.sv; depends on nothing else.
`default_nettype none

package lpsp_pkg;

    // Field widths.
    localparam int COORD_W   = 20;   // lidar coordinate, 1/1024 m
    localparam int CAM_W     = 23;   // camera-frame coordinate
    localparam int RANGE_W   = 20;
    localparam int HFOV_W    = 16;
    localparam int VFOV_W    = 15;
    localparam int FOV_W     = 16;   // common width of both fields of view
    localparam int PIX_W     = 13;
    localparam int STATUS_W  = 2;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    // Datapath widths.
    localparam int PROD_W    = 36;   // Q2.14 coefficient times coordinate
    localparam int SQ_IN_W   = 39;   // square of one coordinate
    localparam int R2_W      = 40;   // squared radius
    localparam int CSQ_W     = 45;   // square of one camera coordinate
    localparam int SQ_W      = 63;   // square root operand and root
    localparam int SQRT_STEPS = 32;
    localparam int ANG_W     = 34;   // angle in 2^-32 turn
    localparam int CORD_W    = 36;   // rotator vector components
    localparam int CORDIC_STEPS = 24;
    localparam int N_W       = 52;   // scaled angle before the division
    localparam int DIV_W     = 32;   // dividend, remainder and limit
    localparam int SIZE_W    = 14;   // image size up to 8192
    localparam int DEG_SCALE = 72000;   // 360 degrees * 100 * 2

    // Reset values of the configuration registers (identity transform).
    localparam logic [CFG_W-1:0]   ROW_X_RESET = 64'h4000_0000_0000_0000;
    localparam logic [CFG_W-1:0]   ROW_Y_RESET = 64'h0000_4000_0000_0000;
    localparam logic [CFG_W-1:0]   ROW_Z_RESET = 64'h0000_0000_4000_0000;
    localparam logic [RANGE_W-1:0] MIN_RANGE_RESET = 20'd0;
    localparam logic [RANGE_W-1:0] MAX_RANGE_RESET = 20'hFFFFF;
    localparam logic [HFOV_W-1:0]  HFOV_RESET = 16'd36000;
    localparam logic [VFOV_W-1:0]  VFOV_RESET = 15'd18000;

    localparam int DEFAULT_IMAGE_WIDTH  = 1920;
    localparam int DEFAULT_IMAGE_HEIGHT = 960;

    typedef enum logic [STATUS_W-1:0] {
        ST_KEPT  = 2'd0,
        ST_RANGE = 2'd1,
        ST_IMAGE = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X     = 3'd0,
        REG_ROW_Y     = 3'd1,
        REG_ROW_Z     = 3'd2,
        REG_MIN_RANGE = 3'd3,
        REG_MAX_RANGE = 3'd4,
        REG_HFOV      = 3'd5,
        REG_VFOV      = 3'd6
    } reg_index_t;

    // Payload carried alongside the square root stages.
    typedef struct packed {
        logic                     rej;
        logic                     th_zero;
        logic signed [ANG_W-1:0]  th_ang;
        logic signed [CORD_W-1:0] th_re;
        logic signed [CORD_W-1:0] th_im;
        logic signed [CAM_W-1:0]  cy;
    } mid_t;

    // Payload of the rotator stages: azimuth and elevation side by side.
    typedef struct packed {
        logic                     rej;
        logic                     th_zero;
        logic signed [ANG_W-1:0]  th_ang;
        logic signed [CORD_W-1:0] th_re;
        logic signed [CORD_W-1:0] th_im;
        logic signed [ANG_W-1:0]  ph_ang;
        logic signed [CORD_W-1:0] ph_re;
        logic signed [CORD_W-1:0] ph_im;
    } cord_t;

    // Payload of the pixel divider stages.
    typedef struct packed {
        logic             rej;
        logic             outside;
        logic [DIV_W-1:0] rem_h;
        logic [DIV_W-1:0] rem_v;
        logic [PIX_W-1:0] quo_h;
        logic [PIX_W-1:0] quo_v;
    } div_t;

    // Arctangent of 2^-i in 2^-32 turn.
    function automatic logic signed [ANG_W-1:0] atan_step(input int i);
        logic signed [ANG_W-1:0] a;
        case (i)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933405;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21354465;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335086;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41721;
            15: a = 34'sd20860;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2607;
            19: a = 34'sd1303;
            20: a = 34'sd651;
            21: a = 34'sd325;
            22: a = 34'sd162;
            23: a = 34'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ----- sv/lidar_point_spherical_projector.sv -----
// Top level of the lidar point spherical projector: range gate, rigid
// transform, square root, two rotators and pixel dividers. Uses lpsp_pkg.
// Throughput: one point per cycle unless the output stalls; the 77 pipeline
// stages and the output register advance together, so a stalled output holds
// every stage in place.
// Reset: aresetn is synchronous and active low; it empties the pipeline and
// returns all configuration registers to their defaults (identity transform).
`default_nettype none

module lidar_point_spherical_projector
    import lpsp_pkg::*;
#(
    parameter int IMAGE_WIDTH  = DEFAULT_IMAGE_WIDTH,
    parameter int IMAGE_HEIGHT = DEFAULT_IMAGE_HEIGHT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // Input points.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [63:0]          s_tdata,   // point_x, point_y, point_z, zero pad
    // Results.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [31:0]               m_tdata,   // pixel_column, pixel_row, zero pad
    output logic [STATUS_W-1:0]       m_tuser,   // status
    // Configuration writes.
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // Stage map: A products, B gate and transform, C camera squares and
    // azimuth pre-rotation, D square root operand, then the square root,
    // the rotators, four pixel scaling stages and the dividers.
    localparam int ST_IQ   = 4;
    localparam int ST_CD   = ST_IQ + SQRT_STEPS;
    localparam int ST_P    = ST_CD + CORDIC_STEPS;
    localparam int ST_DV   = ST_P + 4;
    localparam int NSTAGE  = ST_DV + PIX_W;

    localparam logic [SIZE_W-1:0] WIDTH_C  = SIZE_W'(IMAGE_WIDTH);
    localparam logic [SIZE_W-1:0] HEIGHT_C = SIZE_W'(IMAGE_HEIGHT);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken; the port is to be written only
    // while the pipeline is empty, which the user ensures: the block does not enforce it.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   row_reg [3];
    logic [RANGE_W-1:0] min_range_reg, max_range_reg;
    logic [HFOV_W-1:0]  hfov_reg;
    logic [VFOV_W-1:0]  vfov_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0]    <= ROW_X_RESET;
            row_reg[1]    <= ROW_Y_RESET;
            row_reg[2]    <= ROW_Z_RESET;
            min_range_reg <= MIN_RANGE_RESET;
            max_range_reg <= MAX_RANGE_RESET;
            hfov_reg      <= HFOV_RESET;
            vfov_reg      <= VFOV_RESET;
        end else if (cfg_valid) begin
            case (reg_index_t'(cfg_index))
                REG_ROW_X:     row_reg[0]    <= cfg_data;
                REG_ROW_Y:     row_reg[1]    <= cfg_data;
                REG_ROW_Z:     row_reg[2]    <= cfg_data;
                REG_MIN_RANGE: min_range_reg <= cfg_data[RANGE_W-1:0];
                REG_MAX_RANGE: max_range_reg <= cfg_data[RANGE_W-1:0];
                REG_HFOV:      hfov_reg      <= cfg_data[HFOV_W-1:0];
                REG_VFOV:      vfov_reg      <= cfg_data[VFOV_W-1:0];
                default: ;
            endcase
        end
    end

    // Values derived from the configuration, registered once so they do not
    // sit in the item path. A field of view of zero behaves as one.
    logic [FOV_W-1:0] hfov_eff, vfov_eff;
    logic [R2_W-1:0]  min_sq_reg, max_sq_reg;
    logic [DIV_W-1:0] lim_h_reg, lim_v_reg;

    assign hfov_eff = (hfov_reg == '0) ? FOV_W'(1) : hfov_reg;
    assign vfov_eff = (vfov_reg == '0) ? FOV_W'(1) : FOV_W'(vfov_reg);

    always_ff @(posedge aclk) begin
        min_sq_reg <= R2_W'(min_range_reg) * R2_W'(min_range_reg);
        max_sq_reg <= R2_W'(max_range_reg) * R2_W'(max_range_reg);
        lim_h_reg  <= DIV_W'(WIDTH_C) * DIV_W'(hfov_eff);
        lim_v_reg  <= DIV_W'(HEIGHT_C) * DIV_W'(vfov_eff);
    end

    // ------------------------------------------------------------------
    // Flow control. Every stage moves when the output register is free or
    // being emptied; the valid bits travel in a shift register beside the data.
    // ------------------------------------------------------------------
    logic              adv;
    logic              m_tvalid_reg;
    logic [NSTAGE-1:0] vld_reg, vld_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign vld_next = {vld_reg[NSTAGE-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[NSTAGE-1];
        end
    end

    // ------------------------------------------------------------------
    // Stage A: squares of the coordinates and the nine matrix products.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] pt [3];
    logic signed [2*COORD_W-1:0] sq_full [3];
    logic [SQ_IN_W-1:0]        a_sq_reg [3], a_sq_next [3];
    logic signed [PROD_W-1:0]  a_prod_reg [3][3], a_prod_next [3][3];

    assign pt[0] = s_tdata[COORD_W-1:0];
    assign pt[1] = s_tdata[2*COORD_W-1:COORD_W];
    assign pt[2] = s_tdata[3*COORD_W-1:2*COORD_W];

    always_comb begin : stage_a
        logic signed [15:0] coef;
        for (int c = 0; c < 3; c++) begin
            sq_full[c]   = pt[c] * pt[c];
            a_sq_next[c] = sq_full[c][SQ_IN_W-1:0];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                coef = row_reg[r][63-16*c -: 16];
                a_prod_next[r][c] = PROD_W'(coef) * PROD_W'(pt[c]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage B: range gate on the squared radius and the camera coordinates,
    // rounded to nearest (half up) and shifted by the translation.
    // ------------------------------------------------------------------
    logic                     b_bad_reg, b_bad_next;
    logic signed [CAM_W-1:0]  b_cam_reg [3], b_cam_next [3];

    always_comb begin : stage_b
        logic [R2_W-1:0]    r2;
        logic signed [37:0] acc;
        logic signed [15:0] trans;
        r2 = R2_W'(a_sq_reg[0]) + R2_W'(a_sq_reg[1]) + R2_W'(a_sq_reg[2]);
        b_bad_next = (r2 == '0) || (r2 < min_sq_reg) || (r2 > max_sq_reg);
        for (int r = 0; r < 3; r++) begin
            trans = row_reg[r][15:0];
            acc = 38'(a_prod_reg[r][0]) + 38'(a_prod_reg[r][1])
                + 38'(a_prod_reg[r][2]) + 38'sd8192;
            acc = (acc >>> 14) + 38'(trans);
            b_cam_next[r] = acc[CAM_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage C: camera-origin reject, horizontal squares, and the half-turn
    // pre-rotation of the azimuth vector when it points behind the camera.
    // ------------------------------------------------------------------
    logic [CSQ_W-1:0] c_xx_reg, c_zz_reg, c_xx_next, c_zz_next;
    mid_t             c_mid_reg, c_mid_next;

    always_comb begin : stage_c
        logic signed [2*CAM_W-1:0] px, pz;
        logic signed [CORD_W-1:0]  re0, im0;
        px = b_cam_reg[0] * b_cam_reg[0];
        pz = b_cam_reg[2] * b_cam_reg[2];
        c_xx_next = px[CSQ_W-1:0];
        c_zz_next = pz[CSQ_W-1:0];
        re0 = CORD_W'(b_cam_reg[2]) <<< 8;
        im0 = CORD_W'(b_cam_reg[0]) <<< 8;
        c_mid_next.rej = b_bad_reg || ((b_cam_reg[0] == '0) && (b_cam_reg[1] == '0)
                                       && (b_cam_reg[2] == '0));
        c_mid_next.th_zero = (b_cam_reg[0] == '0) && (b_cam_reg[2] == '0);
        c_mid_next.cy = b_cam_reg[1];
        if (re0 < 0) begin
            c_mid_next.th_ang = (im0 >= 0) ? (ANG_W'(1) <<< 31) : -(ANG_W'(1) <<< 31);
            c_mid_next.th_re  = -re0;
            c_mid_next.th_im  = -im0;
        end else begin
            c_mid_next.th_ang = '0;
            c_mid_next.th_re  = re0;
            c_mid_next.th_im  = im0;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: square root operand (x^2 + z^2) * 2^16.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] d_n_reg, d_n_next;
    mid_t            d_mid_reg;

    assign d_n_next = SQ_W'(CSQ_W'(c_xx_reg + c_zz_reg)) << 16;

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, restoring form.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0] iq_n_reg [SQRT_STEPS], iq_n_next [SQRT_STEPS];
    logic [SQ_W-1:0] iq_r_reg [SQRT_STEPS], iq_r_next [SQRT_STEPS];
    mid_t            iq_mid_reg [SQRT_STEPS], iq_mid_next [SQRT_STEPS];

    always_comb begin : stage_sqrt
        logic [SQ_W-1:0] n_v, r_v, bit_v, t_v;
        for (int k = 0; k < SQRT_STEPS; k++) begin
            n_v   = (k == 0) ? d_n_reg : iq_n_reg[(k == 0) ? 0 : k-1];
            r_v   = (k == 0) ? '0 : iq_r_reg[(k == 0) ? 0 : k-1];
            iq_mid_next[k] = (k == 0) ? d_mid_reg : iq_mid_reg[(k == 0) ? 0 : k-1];
            bit_v = SQ_W'(1) << (2*(SQRT_STEPS-1-k));
            t_v   = r_v + bit_v;
            if (n_v >= t_v) begin
                iq_n_next[k] = n_v - t_v;
                iq_r_next[k] = (r_v >> 1) + bit_v;
            end else begin
                iq_n_next[k] = n_v;
                iq_r_next[k] = r_v >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Rotators: azimuth atan2(x, z) and elevation atan2(y, h), one
    // micro-rotation per stage for both.
    // ------------------------------------------------------------------
    cord_t cd_reg [CORDIC_STEPS], cd_next [CORDIC_STEPS];

    always_comb begin : stage_cordic
        cord_t src;
        mid_t  m;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            m = iq_mid_reg[SQRT_STEPS-1];
            if (i == 0) begin
                src.rej     = m.rej;
                src.th_zero = m.th_zero;
                src.th_ang  = m.th_ang;
                src.th_re   = m.th_re;
                src.th_im   = m.th_im;
                src.ph_ang  = '0;
                src.ph_re   = iq_r_reg[SQRT_STEPS-1][CORD_W-1:0];
                src.ph_im   = CORD_W'(m.cy) <<< 8;
            end else begin
                src = cd_reg[(i == 0) ? 0 : i-1];
            end
            cd_next[i] = src;
            if (src.th_im > 0) begin
                cd_next[i].th_re  = src.th_re + (src.th_im >>> i);
                cd_next[i].th_im  = src.th_im - (src.th_re >>> i);
                cd_next[i].th_ang = src.th_ang + atan_step(i);
            end else begin
                cd_next[i].th_re  = src.th_re - (src.th_im >>> i);
                cd_next[i].th_im  = src.th_im + (src.th_re >>> i);
                cd_next[i].th_ang = src.th_ang - atan_step(i);
            end
            if (src.ph_im > 0) begin
                cd_next[i].ph_re  = src.ph_re + (src.ph_im >>> i);
                cd_next[i].ph_im  = src.ph_im - (src.ph_re >>> i);
                cd_next[i].ph_ang = src.ph_ang + atan_step(i);
            end else begin
                cd_next[i].ph_re  = src.ph_re - (src.ph_im >>> i);
                cd_next[i].ph_im  = src.ph_im + (src.ph_re >>> i);
                cd_next[i].ph_ang = src.ph_ang - atan_step(i);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pixel scaling. n = angle * 72000 + fov * 2^32, then
    // q = floor(n * size / 2^33), and the pixel is floor(q / fov).
    // ------------------------------------------------------------------
    logic                   p1_rej_reg;
    logic signed [N_W-1:0]  p1_mh_reg, p1_mv_reg, p1_mh_next, p1_mv_next;
    logic                   p2_rej_reg, p2_neg_reg, p2_neg_next;
    logic [N_W-2:0]         p2_nh_reg, p2_nv_reg, p2_nh_next, p2_nv_next;
    logic                   p3_rej_reg, p3_neg_reg;
    logic [DIV_W-1:0]       p3_qh_reg, p3_qv_reg, p3_qh_next, p3_qv_next;
    div_t                   p4_reg, p4_next;

    always_comb begin : stage_pixel
        logic signed [ANG_W-1:0] theta;
        logic signed [N_W-1:0]   nh, nv;
        logic [63:0]             prod_h, prod_v;
        theta = cd_reg[CORDIC_STEPS-1].th_zero ? '0 : cd_reg[CORDIC_STEPS-1].th_ang;
        p1_mh_next = N_W'(theta) * N_W'(DEG_SCALE);
        p1_mv_next = N_W'(cd_reg[CORDIC_STEPS-1].ph_ang) * N_W'(DEG_SCALE);

        nh = p1_mh_reg + (N_W'(hfov_eff) <<< 32);
        nv = p1_mv_reg + (N_W'(vfov_eff) <<< 32);
        p2_neg_next = nh[N_W-1] || nv[N_W-1];
        p2_nh_next  = nh[N_W-2:0];
        p2_nv_next  = nv[N_W-2:0];

        prod_h = 64'(p2_nh_reg) * 64'(WIDTH_C);
        prod_v = 64'(p2_nv_reg) * 64'(HEIGHT_C);
        p3_qh_next = DIV_W'(prod_h[63:33]);
        p3_qv_next = DIV_W'(prod_v[63:33]);

        p4_next.rej     = p3_rej_reg;
        p4_next.outside = p3_neg_reg || (p3_qh_reg >= lim_h_reg)
                          || (p3_qv_reg >= lim_v_reg);
        p4_next.rem_h   = p3_qh_reg;
        p4_next.rem_v   = p3_qv_reg;
        p4_next.quo_h   = '0;
        p4_next.quo_v   = '0;
    end

    // ------------------------------------------------------------------
    // Dividers: one quotient bit per stage, most significant first. The
    // quotient is known to fit PIX_W bits whenever the point is inside.
    // ------------------------------------------------------------------
    div_t dv_reg [PIX_W], dv_next [PIX_W];

    always_comb begin : stage_div
        div_t             src;
        logic [DIV_W-1:0] dh, dvv;
        for (int j = 0; j < PIX_W; j++) begin
            src = (j == 0) ? p4_reg : dv_reg[(j == 0) ? 0 : j-1];
            dh  = DIV_W'(hfov_eff) << (PIX_W-1-j);
            dvv = DIV_W'(vfov_eff) << (PIX_W-1-j);
            dv_next[j] = src;
            if (src.rem_h >= dh) begin
                dv_next[j].rem_h = src.rem_h - dh;
                dv_next[j].quo_h[PIX_W-1-j] = 1'b1;
            end
            if (src.rem_v >= dvv) begin
                dv_next[j].rem_v = src.rem_v - dvv;
                dv_next[j].quo_v[PIX_W-1-j] = 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register. Rejected and outside points report zero pixel coordinates.
    // ------------------------------------------------------------------
    status_t          out_status_reg, out_status_next;
    logic [PIX_W-1:0] out_col_reg, out_row_reg, out_col_next, out_row_next;

    always_comb begin : stage_out
        div_t last;
        last = dv_reg[PIX_W-1];
        if (last.rej) begin
            out_status_next = ST_RANGE;
        end else if (last.outside) begin
            out_status_next = ST_IMAGE;
        end else begin
            out_status_next = ST_KEPT;
        end
        out_col_next = (out_status_next == ST_KEPT) ? last.quo_h : '0;
        out_row_next = (out_status_next == ST_KEPT) ? last.quo_v : '0;
    end

    // Data registers of every stage; they move only with the valid bits.
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_sq_reg    <= a_sq_next;
            a_prod_reg  <= a_prod_next;
            b_bad_reg   <= b_bad_next;
            b_cam_reg   <= b_cam_next;
            c_xx_reg    <= c_xx_next;
            c_zz_reg    <= c_zz_next;
            c_mid_reg   <= c_mid_next;
            d_n_reg     <= d_n_next;
            d_mid_reg   <= c_mid_reg;
            iq_n_reg    <= iq_n_next;
            iq_r_reg    <= iq_r_next;
            iq_mid_reg  <= iq_mid_next;
            cd_reg      <= cd_next;
            p1_rej_reg  <= cd_reg[CORDIC_STEPS-1].rej;
            p1_mh_reg   <= p1_mh_next;
            p1_mv_reg   <= p1_mv_next;
            p2_rej_reg  <= p1_rej_reg;
            p2_neg_reg  <= p2_neg_next;
            p2_nh_reg   <= p2_nh_next;
            p2_nv_reg   <= p2_nv_next;
            p3_rej_reg  <= p2_rej_reg;
            p3_neg_reg  <= p2_neg_reg;
            p3_qh_reg   <= p3_qh_next;
            p3_qv_reg   <= p3_qv_next;
            p4_reg      <= p4_next;
            dv_reg      <= dv_next;
            out_status_reg <= out_status_next;
            out_col_reg    <= out_col_next;
            out_row_reg    <= out_row_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {6'b0, out_row_reg, out_col_reg};

endmodule

`default_nettype wire
